/* src/brle_pkg.sv */
// Shared types and constants for the backward run-length run decoder.
package brle_pkg;

    localparam int SCREEN_BYTES = 32768;
    localparam int SPACE_W      = 16;
    localparam int ADDR_W       = 15;
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 7;
    localparam int STAT_W       = 2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFILL = 2'd2;

    // Decoder phase; code 3 is unused and decodes as PH_CTRL
    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_LIT  = 2'd1,
        PH_REP  = 2'd2
    } phase_t;

    // One run result beat
    typedef struct packed {
        logic [ADDR_W-1:0] top_address;
        logic [BYTE_W-1:0] fill_value;
        logic [LEN_W-1:0]  run_length;
        logic [STAT_W-1:0] status;
        logic              done_res;
    } result_t;

endpackage

/* src/brle_decode_core.sv */
// Decoder state and per-byte run computation.
module brle_decode_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic [7:0]               data_byte,
    input  logic                     last,
    output logic                     res_valid,
    output brle_pkg::result_t        res
);
    import brle_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic [SPACE_W-1:0] space_reg, space_next;
    logic               stopped_reg, stopped_next;

    // run decision for the current byte
    logic               ovf;
    logic               have_run;
    logic [ADDR_W-1:0]  run_top;
    logic [LEN_W-1:0]   run_len;
    logic [SPACE_W-1:0] space_after;
    phase_t             phase_after;
    logic [LEN_W-1:0]   count_after;
    logic [SPACE_W-1:0] space_m1;
    logic [SPACE_W-1:0] rep_n;
    logic               close_ok;

    assign space_m1 = space_reg - SPACE_W'(1);
    assign rep_n    = {{(SPACE_W-LEN_W){1'b0}}, count_reg};

    // Work out the run this byte writes and the state it leaves
    always_comb begin
        ovf         = 1'b0;
        have_run    = 1'b0;
        run_top     = '0;
        run_len     = '0;
        space_after = space_reg;
        phase_after = phase_reg;
        count_after = count_reg;
        case (phase_reg)
            PH_LIT: begin
                if (space_reg == '0) begin
                    ovf = 1'b1;
                end else begin
                    have_run    = 1'b1;
                    run_top     = space_m1[ADDR_W-1:0];
                    run_len     = LEN_W'(1);
                    space_after = space_m1;
                    count_after = count_reg - LEN_W'(1);
                    if (count_after == '0) begin
                        phase_after = PH_CTRL;
                    end
                end
            end
            PH_REP: begin
                if (rep_n > space_reg) begin
                    // only what still fits is written
                    ovf         = 1'b1;
                    run_len     = space_reg[LEN_W-1:0];
                    run_top     = (space_reg != '0) ? space_m1[ADDR_W-1:0] : '0;
                    space_after = '0;
                end else if (count_reg != '0) begin
                    have_run    = 1'b1;
                    run_top     = space_m1[ADDR_W-1:0];
                    run_len     = count_reg;
                    space_after = space_reg - rep_n;
                end
                phase_after = PH_CTRL;
                count_after = '0;
            end
            default: begin
                // control byte
                count_after = data_byte[LEN_W-1:0];
                if (data_byte[7]) begin
                    phase_after = PH_REP;
                end else if (data_byte != '0) begin
                    phase_after = PH_LIT;
                end else begin
                    phase_after = PH_CTRL;
                end
            end
        endcase
    end

    assign close_ok = (phase_after == PH_CTRL) && (space_after == '0);

    // Next state
    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        space_next   = space_reg;
        stopped_next = stopped_reg;
        if (accept && !stopped_reg) begin
            phase_next   = phase_after;
            count_next   = count_after;
            space_next   = space_after;
            stopped_next = ovf || last;
        end
    end

    // Result beat
    always_comb begin
        res_valid       = 1'b0;
        res.top_address = run_top;
        res.fill_value  = data_byte;
        res.run_length  = run_len;
        res.status      = ST_OK;
        res.done_res    = 1'b0;
        if (accept && !stopped_reg) begin
            if (ovf) begin
                res_valid    = 1'b1;
                res.status   = ST_OVERFLOW;
                res.done_res = 1'b1;
            end else if (last) begin
                res_valid    = 1'b1;
                res.status   = close_ok ? ST_OK : ST_UNDERFILL;
                res.done_res = 1'b1;
                if (!have_run) begin
                    res.top_address = '0;
                    res.fill_value  = '0;
                    res.run_length  = '0;
                end
            end else begin
                res_valid = have_run;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_CTRL;
            count_reg   <= '0;
            space_reg   <= SPACE_W'(SCREEN_BYTES);
            stopped_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            space_reg   <= space_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

/* src/brle_out_fifo.sv */
// Two-entry result buffer between the decoder and the result channel.
module brle_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  brle_pkg::result_t  push_data,
    output logic               not_full,
    output logic               m_valid,
    input  logic               m_ready,
    output brle_pkg::result_t  pop_data
);
    import brle_pkg::*;

    result_t     mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign m_valid  = (cnt_reg != 2'd0);
    assign not_full = (cnt_reg != 2'd2);
    assign pop      = m_valid && m_ready;
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/backward_rle_run_decoder_unit.sv */
// Top level of the backward run-length run decoder.
// Each result is registered in the two-entry result buffer before it appears on the m_ beats.
// One encoded byte is taken per cycle while s_ready is high; the two-entry result buffer sets s_ready.
// s_ready drops only while both result entries are occupied.
// Reset (aresetn low, synchronous): phase to control byte, screen space full,
// pending count zero, stop flag clear, result buffer empty.
module backward_rle_run_decoder_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [brle_pkg::BYTE_W-1:0]  s_data_byte,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [brle_pkg::ADDR_W-1:0]  m_top_address,
    output logic [brle_pkg::BYTE_W-1:0]  m_fill_value,
    output logic [brle_pkg::LEN_W-1:0]   m_run_length,
    output logic [brle_pkg::STAT_W-1:0]  m_status,
    output logic                         m_done_res
);
    import brle_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign accept = s_valid && s_ready;

    brle_decode_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_data_byte),
        .last      (s_last),
        .res_valid (res_valid),
        .res       (res)
    );

    brle_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .not_full  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .pop_data  (out_res)
    );

    assign m_top_address = out_res.top_address;
    assign m_fill_value  = out_res.fill_value;
    assign m_run_length  = out_res.run_length;
    assign m_status      = out_res.status;
    assign m_done_res    = out_res.done_res;

endmodule

/* src/brle_checker.sv */
// Port-level checks for the backward run-length run decoder, bound to the top level.
module brle_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [brle_pkg::ADDR_W-1:0]  m_top_address,
    input logic [brle_pkg::BYTE_W-1:0]  m_fill_value,
    input logic [brle_pkg::LEN_W-1:0]   m_run_length,
    input logic [brle_pkg::STAT_W-1:0]  m_status,
    input logic                         m_done_res
);
    import brle_pkg::*;

    // the done beat is the final one: nothing follows it
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_done_res |=> !m_valid)
        else $error("result beat after done beat");

    // any error status closes decoding
    a_err_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_OVERFLOW || m_status == ST_UNDERFILL) |-> m_done_res)
        else $error("error status without done");

    // a beat that does not close decoding always carries a run
    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> (m_run_length != '0) && (m_status == ST_OK))
        else $error("empty or flagged run on open beat");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_top_address) &&
            $stable(m_fill_value) && $stable(m_run_length) &&
            $stable(m_status) && $stable(m_done_res))
        else $error("result beat changed while stalled");

endmodule

bind backward_rle_run_decoder_unit brle_checker u_brle_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_top_address (m_top_address),
    .m_fill_value  (m_fill_value),
    .m_run_length  (m_run_length),
    .m_status      (m_status),
    .m_done_res    (m_done_res)
);

/* tb/sv/tb.sv */
// Self-checking testbench for the backward run-length run decoder unit.
`timescale 1ns / 100ps

module tb;
    import brle_pkg::*;

    // Scoreboard: models the decoder and keeps the runs it still expects
    class run_scoreboard;
        logic [SPACE_W-1:0] room;
        phase_t             ph;
        logic [LEN_W-1:0]   count;
        bit                 halted;
        result_t            expected_runs[$];
        int                 errors;
        int                 runs_checked;

        function new();
            room         = SPACE_W'(SCREEN_BYTES);
            ph           = PH_CTRL;
            count        = '0;
            halted       = 1'b0;
            errors       = 0;
            runs_checked = 0;
        endfunction

        function int outstanding();
            return expected_runs.size();
        endfunction

        // Advance the decoder by one accepted byte and queue its run, if any
        function void note_byte(logic [BYTE_W-1:0] b, logic lst);
            result_t          r;
            bit               wrote;
            bit               ovf;
            logic [LEN_W-1:0] n;
            if (halted)
                return;
            r     = '0;
            wrote = 1'b0;
            ovf   = 1'b0;
            case (ph)
                PH_LIT: begin
                    r.fill_value = b;
                    if (room == 0) begin
                        ovf = 1'b1;
                    end else begin
                        r.top_address = ADDR_W'(room - 1);
                        r.run_length  = LEN_W'(1);
                        wrote         = 1'b1;
                        room          = room - SPACE_W'(1);
                        count         = count - LEN_W'(1);
                        if (count == 0)
                            ph = PH_CTRL;
                    end
                end
                PH_REP: begin
                    n            = count;
                    r.fill_value = b;
                    if (n > room) begin
                        // only the bytes that still fit are written
                        ovf           = 1'b1;
                        r.run_length  = LEN_W'(room);
                        r.top_address = (room != 0) ? ADDR_W'(room - 1) : '0;
                        room          = '0;
                    end else if (n != 0) begin
                        r.top_address = ADDR_W'(room - 1);
                        r.run_length  = n;
                        wrote         = 1'b1;
                        room          = room - n;
                    end
                    ph    = PH_CTRL;
                    count = '0;
                end
                default: begin
                    ph = PH_CTRL;
                    if (b[7]) begin
                        count = b[6:0];
                        ph    = PH_REP;
                    end else if (b != 0) begin
                        count = b[6:0];
                        ph    = PH_LIT;
                    end
                end
            endcase

            if (ovf) begin
                halted      = 1'b1;
                r.status    = ST_OVERFLOW;
                r.done_res  = 1'b1;
                expected_runs.push_back(r);
            end else if (lst) begin
                halted = 1'b1;
                if (!wrote)
                    r = '0;
                r.status   = (ph == PH_CTRL && room == 0) ? ST_OK : ST_UNDERFILL;
                r.done_res = 1'b1;
                expected_runs.push_back(r);
            end else if (wrote) begin
                r.status   = ST_OK;
                r.done_res = 1'b0;
                expected_runs.push_back(r);
            end
        endfunction

        // Compare one result beat with the oldest expected run
        function void check_run(result_t got);
            result_t want;
            if (expected_runs.size() == 0) begin
                $error("unexpected result beat: top 0x%04h value 0x%02h len %0d status %0d",
                       got.top_address, got.fill_value, got.run_length, got.status);
                errors++;
                return;
            end
            want = expected_runs.pop_front();
            runs_checked++;
            if (got.top_address !== want.top_address) begin
                $error("top_address: expected %0d, actual %0d",
                       want.top_address, got.top_address);
                errors++;
            end
            if (got.fill_value !== want.fill_value) begin
                $error("fill_value: expected 0x%02h, actual 0x%02h",
                       want.fill_value, got.fill_value);
                errors++;
            end
            if (got.run_length !== want.run_length) begin
                $error("run_length: expected %0d, actual %0d",
                       want.run_length, got.run_length);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.done_res !== want.done_res) begin
                $error("done_res: expected %0d, actual %0d", want.done_res, got.done_res);
                errors++;
            end
        endfunction
    endclass

    localparam int TARGET_BEATS = 1950;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_AT     = 1000;
    localparam int QUIET_LO     = 1200;
    localparam int QUIET_HI     = 1500;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_data_byte;
    logic                s_last;
    logic                m_valid;
    logic                m_ready;
    logic [ADDR_W-1:0]   m_top_address;
    logic [BYTE_W-1:0]   m_fill_value;
    logic [LEN_W-1:0]    m_run_length;
    logic [STAT_W-1:0]   m_status;
    logic                m_done_res;

    run_scoreboard       sb;
    int                  beats_sent;
    int                  plan_room;
    string               ending_desc;

    backward_rle_run_decoder_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_top_address (m_top_address),
        .m_fill_value  (m_fill_value),
        .m_run_length  (m_run_length),
        .m_status      (m_status),
        .m_done_res    (m_done_res)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit quiet_window();
        return beats_sent >= QUIET_LO && beats_sent < QUIET_HI;
    endfunction

    // Monitor: sample both channels on the clock edge
    always @(posedge aclk) begin
        result_t got;
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_byte(s_data_byte, s_last);
            if (m_valid && m_ready) begin
                got.top_address = m_top_address;
                got.fill_value  = m_fill_value;
                got.run_length  = m_run_length;
                got.status      = m_status;
                got.done_res    = m_done_res;
                sb.check_run(got);
            end
        end
    end

    // Result side: random stalls, one long hold, a stretch with no stalls
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && beats_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (quiet_window()) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // One input beat, occasionally preceded by an idle gap with s_valid low
    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic l);
        bit rdy;
        if (!quiet_window() && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_last      <= l;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        beats_sent++;
    endtask

    // Repeat command: count, then the value byte
    task automatic send_repeat(input int n, input logic [BYTE_W-1:0] v, input bit close);
        send_byte({1'b1, 7'(n)}, 1'b0);
        send_byte(v, close);
        plan_room -= (n > plan_room) ? plan_room : n;
    endtask

    // Literal command announcing n bytes, of which the first upto are sent
    task automatic send_literals(input int n, input int upto, input bit close);
        send_byte({1'b0, 7'(n)}, 1'b0);
        for (int i = 1; i <= upto; i++)
            send_byte(8'($urandom_range(0, 255)), close && (i == upto));
        plan_room -= (upto > plan_room) ? plan_room : upto;
    endtask

    // Use max-size repeats until exactly keep bytes of screen remain
    task automatic fill_to(input int keep);
        int n;
        while (plan_room > keep) begin
            n = plan_room - keep;
            if (n > 127)
                n = 127;
            send_repeat(n, 8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Hold the input until every queued run has come out
    task automatic drain_runs();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    // Main stimulus
    initial begin
        int  pick;
        int  n;
        int  beats_left;
        bit  drained;
        sb          = new();
        beats_sent  = 0;
        plan_room   = SCREEN_BYTES;
        drained     = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_last      = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero counts, byte extremes, full-size repeat just below the first literals
        send_byte(8'h00, 1'b0);
        send_repeat(0, 8'h5a, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        plan_room -= 3;
        send_repeat(127, 8'hff, 1'b0);
        send_repeat(1, 8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7f, 1'b0);
        plan_room -= 1;
        send_repeat(2, 8'ha5, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        plan_room -= 2;
        send_repeat(64, 8'h01, 1'b0);

        // Random well-formed commands, paced to use the screen by the end
        while (beats_sent < TARGET_BEATS - 40 && plan_room > 254) begin
            if (!drained && beats_sent >= DRAIN_AT) begin
                drained = 1'b1;
                drain_runs();
            end
            pick       = $urandom_range(0, 99);
            beats_left = TARGET_BEATS - beats_sent;
            if (pick < 5) begin
                send_byte(8'h00, 1'b0);
            end else if (pick < 8) begin
                send_repeat(0, 8'($urandom_range(0, 255)), 1'b0);
            end else if ((plan_room > 17 * beats_left) ? (pick < 85) : (pick < 30)) begin
                n = $urandom_range(1, 127);
                if (n > plan_room - 130)
                    n = plan_room - 130;
                send_repeat(n, 8'($urandom_range(0, 255)), 1'b0);
            end else begin
                pick = $urandom_range(0, 99);
                n = (pick < 70) ? $urandom_range(1, 8) :
                    (pick < 95) ? $urandom_range(9, 40) : $urandom_range(41, 127);
                if (n > plan_room - 130)
                    n = plan_room - 130;
                send_literals(n, n, 1'b0);
            end
        end

        // Close the stream one way or another
        case ($urandom_range(0, 5))
            0: begin
                ending_desc = "exact fill closed by a repeat";
                fill_to($urandom_range(1, 127));
                send_repeat(plan_room, 8'($urandom_range(0, 255)), 1'b1);
            end
            1: begin
                ending_desc = "exact fill closed by a literal";
                fill_to(1);
                send_literals(1, 1, 1'b1);
            end
            2: begin
                ending_desc = "exact fill closed by an empty control byte";
                fill_to(0);
                send_byte(8'h00, 1'b1);
            end
            3: begin
                ending_desc = "underfilled or truncated stream";
                case ($urandom_range(0, 3))
                    0: send_byte({1'($urandom_range(0, 1)), 7'($urandom_range(1, 127))},
                                 1'b1);
                    1: send_literals(5, 3, 1'b1);
                    2: send_repeat($urandom_range(1, 127), 8'($urandom_range(0, 255)),
                                   1'b1);
                    default: send_byte(8'h00, 1'b1);
                endcase
            end
            4: begin
                ending_desc = "repeat running past address zero";
                fill_to($urandom_range(1, 100));
                send_repeat($urandom_range(plan_room + 1, 127), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
            end
            default: begin
                ending_desc = "write into a full screen";
                fill_to(0);
                if ($urandom_range(0, 1))
                    send_literals($urandom_range(1, 127), 1, 1'($urandom_range(0, 1)));
                else
                    send_repeat($urandom_range(1, 127), 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)));
            end
        endcase

        // Once stopped the block must stay silent
        repeat (8)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        s_valid <= 1'b0;

        do @(posedge aclk); while (sb.outstanding() != 0);
        repeat (20) @(posedge aclk);

        $display("Sent %0d encoded beats and checked %0d run results.",
                 beats_sent, sb.runs_checked);
        $display("Stream ended with: %s.", ending_desc);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("[backward_rle_run_decoder_unit] OK");
        else
            $display("[backward_rle_run_decoder_unit] ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("[backward_rle_run_decoder_unit] ERROR");
        $finish;
    end

endmodule
